// File: rtl/shower_max_and_centroid_finder_assert.svh
// Assertion macros for the shower finder; only the event queue module uses them.
// Both macros expect a signal named clk, and SMCF_ASSERT also rst_n, in the scope where it is used.
`ifndef SHOWER_MAX_AND_CENTROID_FINDER_ASSERT_SVH
`define SHOWER_MAX_AND_CENTROID_FINDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SMCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("shower finder assertion failed");
`define SMCF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("shower finder assertion failed");
`else
`define SMCF_ASSERT(lbl, prop)
`define SMCF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/smcf_pkg.sv
package smcf_pkg;

  localparam int MAX_LAYERS = 64;
  localparam int MAX_HITS   = 4096;

  localparam int Z_W     = 16;
  localparam int E_W     = 16;
  localparam int LAYER_W = 6;
  localparam int HITS_W  = 12;
  localparam int ESUM_W  = 28;
  localparam int WSUM_W  = 44;
  localparam int PROD_W  = Z_W + E_W;
  localparam int CENT_W  = 16;

  localparam int LAYER_CAP_I = (MAX_LAYERS - 1 > 63) ? 63 : MAX_LAYERS - 1;
  localparam int HIT_CAP_I   = (MAX_HITS - 1 > 4095) ? 4095 : MAX_HITS - 1;
  localparam logic [LAYER_W-1:0] LAYER_CAP = LAYER_W'(LAYER_CAP_I);
  localparam logic [HITS_W-1:0]  HIT_CAP   = HITS_W'(HIT_CAP_I);

  localparam logic [ESUM_W-1:0] E_MAX = '1;
  localparam logic [WSUM_W-1:0] W_MAX = '1;
  localparam logic [CENT_W-1:0] CENT_MAX = '1;

  // Event queue between the accumulator and the divider.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int DIV_STEPS = WSUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [Z_W-1:0] hit_z;
    logic [E_W-1:0] hit_energy;
    logic           last_hit;
  } hit_t;

  typedef struct packed {
    logic [LAYER_W-1:0] max_energy_layer;
    logic [LAYER_W-1:0] max_hits_layer;
    logic [Z_W-1:0]     max_energy_z;
    logic [Z_W-1:0]     max_hits_z;
    logic [ESUM_W-1:0]  total_energy;
    logic [CENT_W-1:0]  centroid_z;
    logic               zero_energy;
  } result_t;

  // One finished event, waiting for its centroid division.
  typedef struct packed {
    logic [LAYER_W-1:0] max_energy_layer;
    logic [LAYER_W-1:0] max_hits_layer;
    logic [Z_W-1:0]     max_energy_z;
    logic [Z_W-1:0]     max_hits_z;
    logic [ESUM_W-1:0]  total_energy;
    logic [WSUM_W-1:0]  weighted_z_sum;
  } event_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  function automatic logic [ESUM_W-1:0] sat_add_e(input logic [ESUM_W-1:0] a,
                                                  input logic [ESUM_W-1:0] b);
    logic [ESUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ESUM_W] ? E_MAX : s[ESUM_W-1:0];
  endfunction

endpackage

// File: rtl/smcf_front.sv
module smcf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  smcf_pkg::hit_t      in_hit,
  input  smcf_pkg::qstat_t    q_stat,
  output logic                q_push,
  output smcf_pkg::event_t    q_data
);

  // Input register, with the hit's z times energy product formed on entry.
  logic                         s0_v_r, s0_v_nxt;
  smcf_pkg::hit_t               s0_hit_r;
  logic [smcf_pkg::PROD_W-1:0]  s0_prod_r;

  logic                         first_r, first_nxt;
  logic [smcf_pkg::Z_W-1:0]     cur_z_r, cur_z_nxt;
  logic [smcf_pkg::LAYER_W-1:0] lcnt_r, lcnt_nxt;
  logic [smcf_pkg::ESUM_W-1:0]  lsum_r, lsum_nxt;
  logic [smcf_pkg::HITS_W-1:0]  lhits_r, lhits_nxt;
  logic [smcf_pkg::ESUM_W-1:0]  bsum_r, bsum_nxt;
  logic [smcf_pkg::LAYER_W-1:0] bsum_idx_r, bsum_idx_nxt;
  logic [smcf_pkg::Z_W-1:0]     bsum_z_r, bsum_z_nxt;
  logic [smcf_pkg::HITS_W-1:0]  bhits_r, bhits_nxt;
  logic [smcf_pkg::LAYER_W-1:0] bhits_idx_r, bhits_idx_nxt;
  logic [smcf_pkg::Z_W-1:0]     bhits_z_r, bhits_z_nxt;
  logic [smcf_pkg::ESUM_W-1:0]  tot_r, tot_nxt;
  logic [smcf_pkg::WSUM_W-1:0]  wsum_r, wsum_nxt;

  logic                         accept;
  logic                         pend_push;
  logic [smcf_pkg::QCNT_W:0]    room_need;
  logic [smcf_pkg::ESUM_W-1:0]  e_ext;
  logic [smcf_pkg::WSUM_W:0]    wsum_add;
  logic                         new_layer;

  // The item in the input register always retires in the current cycle, so the
  // queue must have room for any event it closes and for one more.
  assign pend_push = s0_v_r && s0_hit_r.last_hit;
  assign room_need = {1'b0, q_stat.count} + {{smcf_pkg::QCNT_W{1'b0}}, pend_push};
  assign in_full   = (room_need >= (smcf_pkg::QCNT_W + 1)'(smcf_pkg::QDEPTH));
  assign accept    = in_push && !in_full;
  assign s0_v_nxt  = accept;

  assign e_ext    = {{(smcf_pkg::ESUM_W - smcf_pkg::E_W){1'b0}}, s0_hit_r.hit_energy};
  assign wsum_add = {1'b0, wsum_r} + (smcf_pkg::WSUM_W + 1)'(s0_prod_r);
  assign new_layer = (s0_hit_r.hit_z != cur_z_r) && (lcnt_r < smcf_pkg::LAYER_CAP);

  always_comb begin
    first_nxt     = first_r;
    cur_z_nxt     = cur_z_r;
    lcnt_nxt      = lcnt_r;
    lsum_nxt      = lsum_r;
    lhits_nxt     = lhits_r;
    bsum_nxt      = bsum_r;
    bsum_idx_nxt  = bsum_idx_r;
    bsum_z_nxt    = bsum_z_r;
    bhits_nxt     = bhits_r;
    bhits_idx_nxt = bhits_idx_r;
    bhits_z_nxt   = bhits_z_r;
    tot_nxt       = tot_r;
    wsum_nxt      = wsum_r;
    q_push        = 1'b0;
    q_data        = '0;
    if (s0_v_r) begin
      tot_nxt  = smcf_pkg::sat_add_e(tot_r, e_ext);
      wsum_nxt = wsum_add[smcf_pkg::WSUM_W] ? smcf_pkg::W_MAX
                                             : wsum_add[smcf_pkg::WSUM_W-1:0];
      if (first_r) begin
        first_nxt     = 1'b0;
        cur_z_nxt     = s0_hit_r.hit_z;
        lcnt_nxt      = '0;
        lsum_nxt      = e_ext;
        lhits_nxt     = smcf_pkg::HITS_W'(1);
        bsum_nxt      = e_ext;
        bsum_idx_nxt  = '0;
        bsum_z_nxt    = s0_hit_r.hit_z;
        bhits_nxt     = smcf_pkg::HITS_W'(1);
        bhits_idx_nxt = '0;
        bhits_z_nxt   = s0_hit_r.hit_z;
      end else begin
        if (new_layer) begin
          lcnt_nxt  = lcnt_r + smcf_pkg::LAYER_W'(1);
          cur_z_nxt = s0_hit_r.hit_z;
          lsum_nxt  = e_ext;
          lhits_nxt = smcf_pkg::HITS_W'(1);
        end else begin
          lsum_nxt = smcf_pkg::sat_add_e(lsum_r, e_ext);
          if (lhits_r < smcf_pkg::HIT_CAP) begin
            lhits_nxt = lhits_r + smcf_pkg::HITS_W'(1);
          end
        end
        // Strict compares keep the earlier layer on a tie.
        if (lsum_nxt > bsum_r) begin
          bsum_nxt     = lsum_nxt;
          bsum_idx_nxt = lcnt_nxt;
          bsum_z_nxt   = cur_z_nxt;
        end
        if (lhits_nxt > bhits_r) begin
          bhits_nxt     = lhits_nxt;
          bhits_idx_nxt = lcnt_nxt;
          bhits_z_nxt   = cur_z_nxt;
        end
      end
      if (s0_hit_r.last_hit) begin
        q_push                  = 1'b1;
        q_data.max_energy_layer = bsum_idx_nxt;
        q_data.max_hits_layer   = bhits_idx_nxt;
        q_data.max_energy_z     = bsum_z_nxt;
        q_data.max_hits_z       = bhits_z_nxt;
        q_data.total_energy     = tot_nxt;
        q_data.weighted_z_sum   = wsum_nxt;
        // Rearm for the next event; the layer state is rewritten by its first hit.
        first_nxt = 1'b1;
        tot_nxt   = '0;
        wsum_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      first_r     <= 1'b1;
      cur_z_r     <= '0;
      lcnt_r      <= '0;
      lsum_r      <= '0;
      lhits_r     <= '0;
      bsum_r      <= '0;
      bsum_idx_r  <= '0;
      bsum_z_r    <= '0;
      bhits_r     <= '0;
      bhits_idx_r <= '0;
      bhits_z_r   <= '0;
      tot_r       <= '0;
      wsum_r      <= '0;
    end else begin
      s0_v_r      <= s0_v_nxt;
      first_r     <= first_nxt;
      cur_z_r     <= cur_z_nxt;
      lcnt_r      <= lcnt_nxt;
      lsum_r      <= lsum_nxt;
      lhits_r     <= lhits_nxt;
      bsum_r      <= bsum_nxt;
      bsum_idx_r  <= bsum_idx_nxt;
      bsum_z_r    <= bsum_z_nxt;
      bhits_r     <= bhits_nxt;
      bhits_idx_r <= bhits_idx_nxt;
      bhits_z_r   <= bhits_z_nxt;
      tot_r       <= tot_nxt;
      wsum_r      <= wsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_hit_r  <= in_hit;
      s0_prod_r <= in_hit.hit_z * in_hit.hit_energy;
    end
  end

endmodule

// File: rtl/smcf_queue.sv
`include "shower_max_and_centroid_finder_assert.svh"

module smcf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  smcf_pkg::event_t  wr_data,
  input  logic              pop,
  output smcf_pkg::event_t  rd_data,
  output smcf_pkg::qstat_t  stat
);

  smcf_pkg::event_t               slot_r [smcf_pkg::QDEPTH];
  logic [smcf_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [smcf_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [smcf_pkg::QCNT_W-1:0]    count_r, count_nxt;

  localparam logic [smcf_pkg::QPTR_W-1:0] LAST_PTR = smcf_pkg::QPTR_W'(smcf_pkg::QDEPTH - 1);

  assign rd_data    = slot_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + smcf_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + smcf_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + smcf_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - smcf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  `SMCF_ASSERT(a_no_overflow, push |-> (count_r < smcf_pkg::QCNT_W'(smcf_pkg::QDEPTH)))
  `SMCF_ASSERT(a_no_underflow, pop |-> (count_r != '0))
  `SMCF_ASSERT(a_count_up, (push && !pop) |=> (count_r == $past(count_r) + smcf_pkg::QCNT_W'(1)))
  `SMCF_ASSERT(a_count_bound, count_r <= smcf_pkg::QCNT_W'(smcf_pkg::QDEPTH))
  `SMCF_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (count_r == '0))

endmodule

// File: rtl/smcf_back.sv
module smcf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  smcf_pkg::qstat_t   q_stat,
  input  smcf_pkg::event_t   q_data,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output smcf_pkg::result_t  out_result
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} state_t;

  state_t                       state_r;
  smcf_pkg::event_t             ev_r;
  logic [smcf_pkg::WSUM_W-1:0]  dvd_r;
  logic [smcf_pkg::ESUM_W-1:0]  dvs_r;
  logic [smcf_pkg::ESUM_W:0]    rem_r;
  logic [smcf_pkg::WSUM_W-1:0]  quo_r;
  logic [smcf_pkg::DCNT_W-1:0]  cnt_r;
  logic                         zero_r;
  logic                         out_v_r;
  smcf_pkg::result_t            out_r;

  logic [smcf_pkg::ESUM_W:0]    rem_sh;
  logic [smcf_pkg::ESUM_W:0]    rem_step;
  logic                         ge;
  logic                         slot_free;
  logic [smcf_pkg::CENT_W-1:0]  cent;

  // Restoring division, one quotient bit per cycle, most significant first.
  assign rem_sh   = {rem_r[smcf_pkg::ESUM_W-1:0], dvd_r[smcf_pkg::WSUM_W-1]};
  assign ge       = (rem_sh >= {1'b0, dvs_r});
  assign rem_step = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;

  assign slot_free = !out_v_r || out_pop;
  assign cent = zero_r ? '0
              : (|quo_r[smcf_pkg::WSUM_W-1:smcf_pkg::CENT_W]) ? smcf_pkg::CENT_MAX
              : quo_r[smcf_pkg::CENT_W-1:0];

  assign q_pop      = (state_r == ST_IDLE) && !q_stat.empty;
  assign out_empty  = !out_v_r;
  assign out_result = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      // A new result may replace the one being popped in the same cycle.
      if ((state_r == ST_FIN) && slot_free) begin
        out_v_r <= 1'b1;
      end else if (out_pop && out_v_r) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            ev_r   <= q_data;
            dvd_r  <= q_data.weighted_z_sum;
            dvs_r  <= q_data.total_energy;
            rem_r  <= '0;
            quo_r  <= '0;
            cnt_r  <= '0;
            zero_r <= (q_data.total_energy == '0);
            state_r <= (q_data.total_energy == '0) ? ST_FIN : ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= rem_step;
          quo_r <= {quo_r[smcf_pkg::WSUM_W-2:0], ge};
          dvd_r <= {dvd_r[smcf_pkg::WSUM_W-2:0], 1'b0};
          if (cnt_r == smcf_pkg::DCNT_W'(smcf_pkg::DIV_STEPS - 1)) begin
            state_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + smcf_pkg::DCNT_W'(1);
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_r.max_energy_layer <= ev_r.max_energy_layer;
            out_r.max_hits_layer   <= ev_r.max_hits_layer;
            out_r.max_energy_z     <= ev_r.max_energy_z;
            out_r.max_hits_z       <= ev_r.max_hits_z;
            out_r.total_energy     <= ev_r.total_energy;
            out_r.centroid_z       <= cent;
            out_r.zero_energy      <= zero_r;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/shower_max_and_centroid_finder.sv
// Shower maximum and centroid finder. Calorimeter hits enter one beat per
// clock while full is low, through a queue-style port (push/full), and are
// accumulated one at a time: the block tracks the current layer's energy
// sum and hit count, the layers holding the largest of each (the earlier
// layer wins a tie), the event's total energy and its energy-weighted z
// sum. A new z value opens a new layer; layer index, hit count and sums
// saturate. The hit flagged last closes the event and hands its figures to
// a two-entry event queue. A divider behind that queue forms the centroid,
// floor(weighted sum / total energy) saturated to 16 bits, one quotient bit
// per cycle: the back end loads the event, divides and writes the result
// register once it is free, skipping the division for zero total energy, in
// which case zero_energy is set and the centroid is 0. Results leave through a
// queue-style port (empty/pop) with one output register, and the divider
// starts on the next event while a result waits there. Hits are taken at
// one per cycle while full is low; short events fill the event queue and
// full then holds the input until the divider has retired an event.
module shower_max_and_centroid_finder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  smcf_pkg::hit_t     in_hit,
  output logic               out_empty,
  input  logic               out_pop,
  output smcf_pkg::result_t  out_result
);

  logic              q_push;
  logic              q_pop;
  smcf_pkg::event_t  q_wr_data;
  smcf_pkg::event_t  q_rd_data;
  smcf_pkg::qstat_t  q_stat;

  // Front end: input register, multiply, and the per-hit accumulators.
  smcf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_hit  (in_hit),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  // Finished events wait here, so the front end keeps taking hits during a division.
  smcf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  // Back end: serial centroid division and the output register.
  smcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (q_rd_data),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (out_result)
  );

endmodule
